### src/sppd_pkg.sv
// ----------------------------------------------------------------------------
// sppd_pkg
// Shared constants, register codes and stage control and status types of the stereo
// ping-pong delay.
// ----------------------------------------------------------------------------
package sppd_pkg;

	localparam int DEF_LINE_DEPTH  = 4096;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int DELAY_BITS     = 12;
	localparam int GAIN_BITS      = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIX      = 2'd2;

	// q1.15 unity and rounding offset
	localparam logic [GAIN_BITS-1:0] Q_ONE = 16'h8000;
	localparam int Q_FRAC     = 15;
	localparam int ROUND_HALF = 16384;

	// result buffer entries, also the most transactions that may be in flight
	localparam int OUT_DEPTH = 8;

	typedef struct packed {
		logic valid;
		logic bypass;
	} stage_ctl_t;

	typedef struct packed {
		logic valid_s2;
		logic valid_s3;
	} mix_status_t;

endpackage

### src/stereo_ping_pong_delay_unit.sv
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay_unit
// Stereo ping-pong delay with feedback and dry/wet crossfade, Q1.15.
// ----------------------------------------------------------------------------
// Takes one stereo frame per clock cycle and returns one result frame per
// transaction after the line stage, the mix stages and the result buffer. The
// rate is set by the delay line RAMs: each frame does one read and one write
// of each line per cycle, with the write of a frame forwarded to the read of
// the next frame when the delay is one. Up to 8 frames may be in flight; the
// input stalls only when the result buffer is backed up. The lines need no
// clearing pass after reset: the fill count keeps unwritten entries from
// being read. Register 0 sets the delay (0 bypasses, longer than the line
// saturates), register 1 the feedback gain and register 2 the wet mix; gains
// above one are held at one. Write registers only while no frame is in flight.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay_unit #(
	parameter int LINE_DEPTH  = sppd_pkg::DEF_LINE_DEPTH,
	parameter int SAMPLE_BITS = sppd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sppd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [sppd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SAMPLE_BITS-1:0]          in_left,
	input  logic signed [SAMPLE_BITS-1:0]          in_right,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [SAMPLE_BITS-1:0]          out_left,
	output logic signed [SAMPLE_BITS-1:0]          out_right
);

	import sppd_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [AW-1:0]        delay_q;
	logic [GAIN_BITS-1:0] gain_q;
	logic [GAIN_BITS-1:0] mix_q;
	logic [CW-1:0]        cnt_q;

	logic                      cfg_wr;
	logic                      delay_wr;
	logic [DELAY_BITS-1:0]     delay_raw;
	logic [GAIN_BITS-1:0]      gain_raw;
	logic                      in_acc;
	logic                      out_acc;
	stage_ctl_t                ctl_s1;
	mix_status_t               mix_status;
	logic signed [SAMPLE_BITS-1:0] x_left;
	logic signed [SAMPLE_BITS-1:0] x_right;
	logic signed [SAMPLE_BITS-1:0] wet_left;
	logic signed [SAMPLE_BITS-1:0] wet_right;
	logic                      res_valid;
	logic [SAMPLE_BITS-1:0]    res_left;
	logic [SAMPLE_BITS-1:0]    res_right;
	logic [SAMPLE_BITS-1:0]    fifo_left;
	logic [SAMPLE_BITS-1:0]    fifo_right;
	logic [CW-1:0]             fifo_level;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign delay_wr  = cfg_wr && (cfg_index == REG_DELAY);
	assign delay_raw = cfg_data[DELAY_BITS-1:0];
	assign gain_raw  = (cfg_data > Q_ONE) ? Q_ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			gain_q  <= '0;
			mix_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_DELAY: begin
					if (32'(delay_raw) > 32'(LINE_DEPTH - 1)) begin
						delay_q <= AW'(LINE_DEPTH - 1);
					end else begin
						delay_q <= AW'(delay_raw);
					end
				end
				REG_FEEDBACK: begin
					gain_q <= gain_raw;
				end
				REG_MIX: begin
					mix_q <= gain_raw;
				end
				default: begin
				end
			endcase
		end
	end

	// transactions accepted but not yet delivered
	assign in_ready = (cnt_q < CW'(OUT_DEPTH));
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	sppd_core #(
		.LINE_DEPTH  (LINE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.in_left   (in_left),
		.in_right  (in_right),
		.delay     (delay_q),
		.gain      (gain_q),
		.clear     (delay_wr),
		.ctl_s1    (ctl_s1),
		.x_left    (x_left),
		.x_right   (x_right),
		.wet_left  (wet_left),
		.wet_right (wet_right)
	);

	sppd_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.x_left    (x_left),
		.x_right   (x_right),
		.wet_left  (wet_left),
		.wet_right (wet_right),
		.mix       (mix_q),
		.status    (mix_status),
		.res_valid (res_valid),
		.res_left  (res_left),
		.res_right (res_right)
	);

	sppd_out_fifo #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (res_valid),
		.wr_left   (res_left),
		.wr_right  (res_right),
		.rd_en     (out_acc),
		.not_empty (out_valid),
		.rd_left   (fifo_left),
		.rd_right  (fifo_right),
		.level     (fifo_level)
	);

	assign out_left  = $signed(fifo_left);
	assign out_right = $signed(fifo_right);

	// in-flight count never passes the buffer size
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(OUT_DEPTH))
		else $error("in-flight count exceeds result buffer");

	// every accepted transaction sits in exactly one stage or the buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'(ctl_s1.valid) + CW'(mix_status.valid_s2)
			+ CW'(mix_status.valid_s3) + fifo_level)
		else $error("transaction lost or duplicated in pipeline");

	// an accepted frame enters the line stage on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> ctl_s1.valid && cnt_q != '0)
		else $error("accepted transaction missing from line stage");

endmodule

### src/sppd_line_ram.sv
// ----------------------------------------------------------------------------
// sppd_line_ram
// Simple dual-port delay line memory, one write and one registered read
// per cycle; a read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module sppd_line_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### src/sppd_core.sv
// ----------------------------------------------------------------------------
// sppd_core
// Delay line ring: pointer and fill tracking, line reads, feedback write
// back and the cross-coupled wet state.
// ----------------------------------------------------------------------------
module sppd_core #(
	parameter int LINE_DEPTH  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic signed [SAMPLE_BITS-1:0]       in_left,
	input  logic signed [SAMPLE_BITS-1:0]       in_right,
	input  logic [$clog2(LINE_DEPTH)-1:0]       delay,
	input  logic [sppd_pkg::GAIN_BITS-1:0]      gain,
	input  logic                                clear,
	output sppd_pkg::stage_ctl_t                ctl_s1,
	output logic signed [SAMPLE_BITS-1:0]       x_left,
	output logic signed [SAMPLE_BITS-1:0]       x_right,
	output logic signed [SAMPLE_BITS-1:0]       wet_left,
	output logic signed [SAMPLE_BITS-1:0]       wet_right
);

	import sppd_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int SB = SAMPLE_BITS;
	localparam int FW = SB + GAIN_BITS + 1;
	localparam int EW = SB + 2;
	localparam logic signed [FW-1:0] FB_HALF = FW'(ROUND_HALF);
	localparam logic signed [EW-1:0] SMAX = EW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] SMIN = -SMAX - EW'(1);

	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;
	logic signed [SB-1:0] last_wet_l_q;
	logic signed [SB-1:0] last_wet_r_q;

	logic                 valid_s1;
	logic                 bypass_s1;
	logic                 hit_s1;
	logic [AW-1:0]        wp_s1;
	logic signed [SB-1:0] xl_s1;
	logic signed [SB-1:0] xr_s1;
	logic                 fwd_s1;
	logic [SB-1:0]        fwd_l_s1;
	logic [SB-1:0]        fwd_r_s1;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wp_next;
	logic          bypass;
	logic          hit;
	logic          ram_we;
	logic [SB-1:0] wdata_l;
	logic [SB-1:0] wdata_r;
	logic [SB-1:0] ram_l;
	logic [SB-1:0] ram_r;
	logic [SB-1:0] rdata_l;
	logic [SB-1:0] rdata_r;

	logic signed [FW-1:0] fb_prod;
	logic signed [FW-1:0] fb_rnd;
	logic signed [EW-1:0] fb_sum;

	// address of the entry written delay transactions ago
	always_comb begin
		if (wp_q >= delay) begin
			rd_addr = wp_q - delay;
		end else begin
			rd_addr = AW'({1'b0, wp_q} + (AW + 1)'(LINE_DEPTH) - {1'b0, delay});
		end
	end

	assign wp_next = (wp_q == AW'(LINE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign bypass  = (delay == '0);
	assign hit     = (fill_q >= {1'b0, delay});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (clear) begin
			fill_q <= '0;
		end else if (accept && !bypass) begin
			wp_q   <= wp_next;
			fill_q <= hit ? {1'b0, delay} + (AW + 1)'(1) : fill_q + (AW + 1)'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bypass_s1 <= bypass;
			hit_s1    <= hit;
			wp_s1     <= wp_q;
			xl_s1     <= in_left;
			xr_s1     <= in_right;
		end
		// read of the entry being written this cycle takes the new data
		fwd_s1   <= ram_we && (wp_s1 == rd_addr);
		fwd_l_s1 <= wdata_l;
		fwd_r_s1 <= wdata_r;
	end

	// left line input: input plus rounded feedback of the last right wet sample
	assign fb_prod = last_wet_r_q * $signed({1'b0, gain});
	assign fb_rnd  = (fb_prod + FB_HALF) >>> Q_FRAC;
	assign fb_sum  = EW'(xl_s1) + EW'(fb_rnd);

	always_comb begin
		if (fb_sum > SMAX) begin
			wdata_l = SB'(SMAX);
		end else if (fb_sum < SMIN) begin
			wdata_l = SB'(SMIN);
		end else begin
			wdata_l = SB'(fb_sum);
		end
	end

	assign wdata_r = last_wet_l_q;
	assign ram_we  = valid_s1 && !bypass_s1;

	sppd_line_ram #(
		.DEPTH (LINE_DEPTH),
		.WIDTH (SB)
	) u_left_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_s1),
		.wdata (wdata_l),
		.raddr (rd_addr),
		.rdata (ram_l)
	);

	sppd_line_ram #(
		.DEPTH (LINE_DEPTH),
		.WIDTH (SB)
	) u_right_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_s1),
		.wdata (wdata_r),
		.raddr (rd_addr),
		.rdata (ram_r)
	);

	assign rdata_l = fwd_s1 ? fwd_l_s1 : ram_l;
	assign rdata_r = fwd_s1 ? fwd_r_s1 : ram_r;

	// wet stays zero in bypass and until the line has filled up to the delay
	assign wet_left  = (hit_s1 && !bypass_s1) ? $signed(rdata_l) : '0;
	assign wet_right = (hit_s1 && !bypass_s1) ? $signed(rdata_r) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_wet_l_q <= '0;
			last_wet_r_q <= '0;
		end else if (clear) begin
			last_wet_l_q <= '0;
			last_wet_r_q <= '0;
		end else if (ram_we) begin
			last_wet_l_q <= wet_left;
			last_wet_r_q <= wet_right;
		end
	end

	assign ctl_s1.valid  = valid_s1;
	assign ctl_s1.bypass = bypass_s1;
	assign x_left        = xl_s1;
	assign x_right       = xr_s1;

endmodule

### src/sppd_mix.sv
// ----------------------------------------------------------------------------
// sppd_mix
// Dry/wet crossfade: difference times mix, then rounding and saturation.
// ----------------------------------------------------------------------------
module sppd_mix #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sppd_pkg::stage_ctl_t           ctl_s1,
	input  logic signed [SAMPLE_BITS-1:0]  x_left,
	input  logic signed [SAMPLE_BITS-1:0]  x_right,
	input  logic signed [SAMPLE_BITS-1:0]  wet_left,
	input  logic signed [SAMPLE_BITS-1:0]  wet_right,
	input  logic [sppd_pkg::GAIN_BITS-1:0] mix,
	output sppd_pkg::mix_status_t          status,
	output logic                           res_valid,
	output logic [SAMPLE_BITS-1:0]         res_left,
	output logic [SAMPLE_BITS-1:0]         res_right
);

	import sppd_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int DW = SB + 1;
	localparam int PW = SB + GAIN_BITS + 2;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] MIX_HALF = SW'(ROUND_HALF);
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	logic                 valid_s2;
	logic                 bypass_s2;
	logic signed [SB-1:0] xl_s2;
	logic signed [SB-1:0] xr_s2;
	logic signed [SB-1:0] wl_s2;
	logic signed [SB-1:0] wr_s2;

	logic                 valid_s3;
	logic signed [SB-1:0] xl_s3;
	logic signed [SB-1:0] xr_s3;
	logic signed [PW-1:0] pl_s3;
	logic signed [PW-1:0] pr_s3;

	logic [GAIN_BITS-1:0] mix_eff;
	logic signed [DW-1:0] dl;
	logic signed [DW-1:0] dr;
	logic signed [PW-1:0] pl;
	logic signed [PW-1:0] pr;
	logic signed [SW-1:0] sl;
	logic signed [SW-1:0] sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= ctl_s1.valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		bypass_s2 <= ctl_s1.bypass;
		xl_s2     <= x_left;
		xr_s2     <= x_right;
		wl_s2     <= wet_left;
		wr_s2     <= wet_right;
		xl_s3     <= xl_s2;
		xr_s3     <= xr_s2;
		pl_s3     <= pl;
		pr_s3     <= pr;
	end

	// x*(1-m) + w*m written as x*1 + (w-x)*m
	assign mix_eff = bypass_s2 ? '0 : mix;
	assign dl      = DW'(wl_s2) - DW'(xl_s2);
	assign dr      = DW'(wr_s2) - DW'(xr_s2);
	assign pl      = dl * $signed({1'b0, mix_eff});
	assign pr      = dr * $signed({1'b0, mix_eff});

	assign sl = ((SW'(xl_s3) <<< Q_FRAC) + SW'(pl_s3) + MIX_HALF) >>> Q_FRAC;
	assign sr = ((SW'(xr_s3) <<< Q_FRAC) + SW'(pr_s3) + MIX_HALF) >>> Q_FRAC;

	always_comb begin
		if (sl > SMAX) begin
			res_left = SB'(SMAX);
		end else if (sl < SMIN) begin
			res_left = SB'(SMIN);
		end else begin
			res_left = SB'(sl);
		end
		if (sr > SMAX) begin
			res_right = SB'(SMAX);
		end else if (sr < SMIN) begin
			res_right = SB'(SMIN);
		end else begin
			res_right = SB'(sr);
		end
	end

	assign res_valid       = valid_s3;
	assign status.valid_s2 = valid_s2;
	assign status.valid_s3 = valid_s3;

endmodule

### src/sppd_out_fifo.sv
// ----------------------------------------------------------------------------
// sppd_out_fifo
// Result buffer between the free-running pipeline and the output channel.
// ----------------------------------------------------------------------------
module sppd_out_fifo #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [SAMPLE_BITS-1:0]                  wr_left,
	input  logic [SAMPLE_BITS-1:0]                  wr_right,
	input  logic                                    rd_en,
	output logic                                    not_empty,
	output logic [SAMPLE_BITS-1:0]                  rd_left,
	output logic [SAMPLE_BITS-1:0]                  rd_right,
	output logic [$clog2(sppd_pkg::OUT_DEPTH+1)-1:0] level
);

	import sppd_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [2*SAMPLE_BITS-1:0] buf_q [OUT_DEPTH];
	logic [PW-1:0]            wr_ptr_q;
	logic [PW-1:0]            rd_ptr_q;
	logic [CW-1:0]            level_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= {wr_left, wr_right};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			level_q <= level_q + CW'(wr_en) - CW'(rd_en);
		end
	end

	assign not_empty = (level_q != '0);
	assign rd_left   = buf_q[rd_ptr_q][2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign rd_right  = buf_q[rd_ptr_q][SAMPLE_BITS-1:0];
	assign level     = level_q;

endmodule
